FILE: rtl/core/linear_regression_gradient_descent_assert.svh
// Assertion macros used by the checker file.
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_ASSERT_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_ASSERT_SVH

// Same-cycle implication.
`define LRGD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrgd assertion failed");

// Next-cycle implication.
`define LRGD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrgd assertion failed");

// Hold a stalled payload field until its transfer.
`define LRGD_ASSERT_HOLD(lbl, clk, rst, vld, rdy, sig) \
   lbl: assert property (@(posedge clk) disable iff (rst) \
      ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
      else $error("lrgd assertion failed");

`endif

FILE: rtl/core/lrgd_pkg.sv
`default_nettype none
package lrgd_pkg;

   localparam int IDX_W     = 4;
   localparam int CSR_IDX_W = 4;
   localparam int QUO_W     = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARNING_RATE   = 4'd0,
      CSR_FEATURE_COUNT   = 4'd1,
      CSR_STOP_THRESHOLD  = 4'd2,
      CSR_ITERATION_LIMIT = 4'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_STORE, OP_READ, OP_INIT_RUN, OP_CLR_EPOCH, OP_PRED_INIT,
      OP_MUL_WX, OP_ACC_PRED, OP_RES_G, OP_RES_E, OP_MUL_RX, OP_ACC_GRAD,
      OP_MUL_RR, OP_ACC_SQ, OP_DIV_GRAD, OP_WAIT_G, OP_MUL_LR, OP_ACC_W,
      OP_DIV_ERR, OP_WAIT_E, OP_CHECK, OP_LOAD_OUT
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_EPOCH, ST_READ, ST_PRED0, ST_PMUL, ST_PACC, ST_RES,
      ST_GMUL, ST_GACC, ST_SQMUL, ST_SQACC, ST_DIVG, ST_DIVG_WAIT, ST_LRMUL,
      ST_WACC, ST_DIVE, ST_DIVE_WAIT, ST_CHECK, ST_LOAD, ST_SEND
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type        op;
      logic [IDX_W-1:0] idx;
      logic             last;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic conv_hit;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return s[63:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lrgd_if.sv
`default_nettype none
interface lrgd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] feature_0;
   logic [31:0] feature_1;
   logic [31:0] feature_2;
   logic [31:0] feature_3;
   logic [31:0] target_y;
   logic        final_point;
   modport source (output valid, feature_0, feature_1, feature_2, feature_3, target_y,
                   final_point, input ready);
   modport sink (input valid, feature_0, feature_1, feature_2, feature_3, target_y,
                 final_point, output ready);
endinterface

interface lrgd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  weight_index;
   logic [31:0] weight_value;
   logic        converged;
   logic [31:0] mean_error;
   logic        last_weight;
   modport source (output valid, weight_index, weight_value, converged, mean_error,
                   last_weight, input ready);
   modport sink (input valid, weight_index, weight_value, converged, mean_error,
                 last_weight, output ready);
endinterface

interface lrgd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lrgd_pkg::CSR_IDX_W-1:0] index;
   logic [31:0]                    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/linear_regression_gradient_descent.sv
// Linear regression fit by batch gradient descent, Q16.16 fixed point.
// req_ch takes one training point per transfer (four features, target,
// final_point); points load at one per cycle. The transfer with final_point
// set closes the set (points past MAX_POINTS are dropped) and starts descent
// from zero weights; req_ch.ready stays low until the run's results are out.
// Each epoch makes a gradient pass and an error pass over the N points
// and F features; one shared multiplier serves both passes, and a
// one-bit-per-cycle 64-bit divider forms each mean gradient and the mean
// squared error. Epochs repeat until the error change is within
// stop_threshold or iteration_limit is reached.
// rsp_ch then carries F + 1 transfers, bias first; a low rsp_ch.ready
// holds the current result unchanged.
// csr_ch writes a register per transfer (index 0 learning_rate, 1
// feature_count, 2 stop_threshold, 3 iteration_limit) and is always ready.
// Synchronous reset restores default registers and an empty training set.
`default_nettype none
module linear_regression_gradient_descent #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_FEATURES = 4
) (
   input  logic              clock,
   input  logic              reset,
   lrgd_req_if.sink          req_ch,
   lrgd_rsp_if.source        rsp_ch,
   lrgd_csr_if.sink          csr_ch
);
   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);

   logic [23:0] lr_ff;
   logic [2:0]  fc_ff;
   logic [31:0] thr_ff;
   logic [15:0] lim_ff;

   lrgd_pkg::dp_cmd_type    cmd;
   lrgd_pkg::dp_status_type status;
   logic [PW-1:0]           addr;
   logic [NW-1:0]           n;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= 24'd167772;
         fc_ff  <= 3'd4;
         thr_ff <= 32'd1;
         lim_ff <= 16'd10000;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            lrgd_pkg::CSR_LEARNING_RATE:   lr_ff  <= csr_ch.data[23:0];
            lrgd_pkg::CSR_FEATURE_COUNT:   fc_ff  <= csr_ch.data[2:0];
            lrgd_pkg::CSR_STOP_THRESHOLD:  thr_ff <= csr_ch.data;
            lrgd_pkg::CSR_ITERATION_LIMIT: lim_ff <= csr_ch.data[15:0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   lrgd_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_FEATURES(MAX_FEATURES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_final (req_ch.final_point),
      .rsp_ready (rsp_ch.ready),
      .cfg_fc    (fc_ff),
      .cfg_lim   (lim_ff),
      .status    (status),
      .cmd       (cmd),
      .addr      (addr),
      .n         (n),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid)
   );

   lrgd_dp #(.MAX_POINTS(MAX_POINTS), .MAX_FEATURES(MAX_FEATURES)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .addr         (addr),
      .n            (n),
      .cfg_lr       (lr_ff),
      .cfg_thr      (thr_ff),
      .feature_0    (req_ch.feature_0),
      .feature_1    (req_ch.feature_1),
      .feature_2    (req_ch.feature_2),
      .feature_3    (req_ch.feature_3),
      .target_y     (req_ch.target_y),
      .status       (status),
      .weight_index (rsp_ch.weight_index),
      .weight_value (rsp_ch.weight_value),
      .converged    (rsp_ch.converged),
      .mean_error   (rsp_ch.mean_error),
      .last_weight  (rsp_ch.last_weight)
   );
endmodule
`default_nettype wire

FILE: rtl/core/lrgd_div.sv
`default_nettype none
module lrgd_div #(
   parameter int MAX_POINTS = 1024,
   localparam int NW = $clog2(MAX_POINTS + 1),
   localparam int QW = lrgd_pkg::QUO_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic          neg,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient,
   output logic          quotient_neg
);
   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, done_ff, neg_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] rem_ff, rem_in, d_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [NW:0]   trial;
   logic          fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[QW-1]};
      fits   = trial >= {1'b0, d_ff};
      rem_in = fits ? NW'(trial - {1'b0, d_ff}) : NW'(trial);
      quo_in = {quo_ff[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(1));
         if (start) busy_ff <= 1'b1;
         else if (busy_ff && (cnt_ff == CW'(1))) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
         cnt_ff <= CW'(QW);
         neg_ff <= neg;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done         = done_ff;
   assign quotient     = quo_ff;
   assign quotient_neg = neg_ff;
endmodule
`default_nettype wire

FILE: rtl/core/lrgd_dp.sv
`default_nettype none
module lrgd_dp #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_FEATURES = 4,
   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int NW = $clog2(MAX_POINTS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lrgd_pkg::dp_cmd_type    cmd,
   input  logic [PW-1:0]           addr,
   input  logic [NW-1:0]           n,
   input  logic [23:0]             cfg_lr,
   input  logic [31:0]             cfg_thr,
   input  logic [31:0]             feature_0,
   input  logic [31:0]             feature_1,
   input  logic [31:0]             feature_2,
   input  logic [31:0]             feature_3,
   input  logic [31:0]             target_y,
   output lrgd_pkg::dp_status_type status,
   output logic [2:0]              weight_index,
   output logic [31:0]             weight_value,
   output logic                    converged,
   output logic [31:0]             mean_error,
   output logic                    last_weight
);
   localparam int KW = $clog2(MAX_FEATURES + 1);
   localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int IW = lrgd_pkg::IDX_W;

   typedef logic [MAX_FEATURES-1:0][31:0] row_type;

   row_type            in_row, row_ff;
   row_type            feat_mem_ff [MAX_POINTS];
   logic [31:0]        targ_mem_ff [MAX_POINTS];
   logic signed [31:0] y_ff;

   logic signed [31:0] w_ff [MAX_FEATURES+1];
   logic signed [63:0] g_ff [MAX_FEATURES+1];
   logic signed [63:0] pred_ff;
   logic signed [31:0] r_ff, mg_ff;
   logic [63:0]        esum_ff, cur_ff, prev_ff;
   logic               conv_ff;
   logic signed [65:0] prod_ff;
   logic [2:0]         out_idx_ff;
   logic [31:0]        out_w_ff;
   logic               out_last_ff;

   logic [KW-1:0]      widx;
   logic [FW-1:0]      fi;
   logic signed [31:0] fsel, wsel, r_in, mg_in, w_in;
   logic signed [63:0] gsel, g2, p64, fl16, fl24;
   logic signed [32:0] mul_a, mul_b;
   logic [63:0]        sq, esum_in, g2_mag, ediff, div_dividend, div_q;
   logic [64:0]        esum_sum;
   logic               hit, div_start, div_neg, div_done, div_qneg;
   logic signed [65:0] qv;

   always_comb begin
      for (int k = 0; k < MAX_FEATURES; k++) begin
         case (k)
            0:       in_row[k] = feature_0;
            1:       in_row[k] = feature_1;
            2:       in_row[k] = feature_2;
            3:       in_row[k] = feature_3;
            default: in_row[k] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == lrgd_pkg::OP_STORE) begin
         feat_mem_ff[addr] <= in_row;
         targ_mem_ff[addr] <= target_y;
      end
      if (cmd.op == lrgd_pkg::OP_READ) begin
         row_ff <= feat_mem_ff[addr];
         y_ff   <= targ_mem_ff[addr];
      end
   end

   always_comb begin
      widx = KW'(cmd.idx);
      fi   = FW'(cmd.idx - IW'(1));
      fsel = row_ff[fi];
      wsel = w_ff[widx];
      gsel = g_ff[widx];
      case (cmd.op)
         lrgd_pkg::OP_MUL_WX: begin
            mul_a = {wsel[31], wsel};
            mul_b = {fsel[31], fsel};
         end
         lrgd_pkg::OP_MUL_RX: begin
            mul_a = {r_ff[31], r_ff};
            mul_b = {fsel[31], fsel};
         end
         lrgd_pkg::OP_MUL_RR: begin
            mul_a = {r_ff[31], r_ff};
            mul_b = {r_ff[31], r_ff};
         end
         lrgd_pkg::OP_MUL_LR: begin
            mul_a = {9'd0, cfg_lr};
            mul_b = {mg_ff[31], mg_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      p64      = prod_ff[63:0];
      fl16     = p64 >>> 16;
      fl24     = p64 >>> 24;
      r_in     = lrgd_pkg::sat32({{34{y_ff[31]}}, y_ff} - {{2{pred_ff[63]}}, pred_ff});
      sq       = {16'd0, prod_ff[63:16]};
      esum_sum = {1'b0, esum_ff} + {1'b0, sq};
      esum_in  = esum_sum[64] ? '1 : esum_sum[63:0];
      g2       = lrgd_pkg::sat_add64(gsel, gsel);
      g2_mag   = g2[63] ? (~g2 + 64'd1) : g2;
      div_start    = (cmd.op == lrgd_pkg::OP_DIV_GRAD) || (cmd.op == lrgd_pkg::OP_DIV_ERR);
      div_dividend = (cmd.op == lrgd_pkg::OP_DIV_ERR) ? esum_ff : g2_mag;
      div_neg      = (cmd.op == lrgd_pkg::OP_DIV_GRAD) && g2[63];
      qv    = div_qneg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
      mg_in = lrgd_pkg::sat32(qv);
      w_in  = lrgd_pkg::sat32({{34{wsel[31]}}, wsel} + {{2{fl24[63]}}, fl24});
      ediff = (cur_ff >= prev_ff) ? cur_ff - prev_ff : prev_ff - cur_ff;
      hit   = ediff <= {32'd0, cfg_thr};
   end

   lrgd_div #(.MAX_POINTS(MAX_POINTS)) u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend     (div_dividend),
      .neg          (div_neg),
      .divisor      (n),
      .done         (div_done),
      .quotient     (div_q),
      .quotient_neg (div_qneg)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         lrgd_pkg::OP_INIT_RUN: begin
            for (int j = 0; j <= MAX_FEATURES; j++) w_ff[j] <= '0;
            prev_ff <= '0;
         end
         lrgd_pkg::OP_CLR_EPOCH: begin
            for (int j = 0; j <= MAX_FEATURES; j++) g_ff[j] <= '0;
            esum_ff <= '0;
         end
         lrgd_pkg::OP_PRED_INIT: pred_ff <= {{32{w_ff[0][31]}}, w_ff[0]};
         lrgd_pkg::OP_ACC_PRED:  pred_ff <= pred_ff + fl16;
         lrgd_pkg::OP_RES_G: begin
            r_ff    <= r_in;
            g_ff[0] <= lrgd_pkg::sat_add64(g_ff[0], {{32{r_in[31]}}, r_in});
         end
         lrgd_pkg::OP_RES_E:    r_ff <= r_in;
         lrgd_pkg::OP_ACC_GRAD: g_ff[widx] <= lrgd_pkg::sat_add64(gsel, fl16);
         lrgd_pkg::OP_ACC_SQ:   esum_ff <= esum_in;
         lrgd_pkg::OP_WAIT_G: begin
            if (div_done) mg_ff <= mg_in;
         end
         lrgd_pkg::OP_ACC_W:    w_ff[widx] <= w_in;
         lrgd_pkg::OP_WAIT_E: begin
            if (div_done) cur_ff <= div_q;
         end
         lrgd_pkg::OP_CHECK: begin
            prev_ff <= cur_ff;
            conv_ff <= hit;
         end
         lrgd_pkg::OP_LOAD_OUT: begin
            out_idx_ff  <= 3'(cmd.idx);
            out_w_ff    <= wsel;
            out_last_ff <= cmd.last;
         end
         default: ;
      endcase
   end

   assign status.div_done = div_done;
   assign status.conv_hit = hit;
   assign weight_index    = out_idx_ff;
   assign weight_value    = out_w_ff;
   assign last_weight     = out_last_ff;
   assign converged       = conv_ff;
   assign mean_error      = (prev_ff[63:32] != 32'd0) ? '1 : prev_ff[31:0];
endmodule
`default_nettype wire

FILE: rtl/core/lrgd_ctrl.sv
`default_nettype none
module lrgd_ctrl #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_FEATURES = 4,
   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int NW = $clog2(MAX_POINTS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_final,
   input  logic                    rsp_ready,
   input  logic [2:0]              cfg_fc,
   input  logic [15:0]             cfg_lim,
   input  lrgd_pkg::dp_status_type status,
   output lrgd_pkg::dp_cmd_type    cmd,
   output logic [PW-1:0]           addr,
   output logic [NW-1:0]           n,
   output logic                    req_ready,
   output logic                    rsp_valid
);
   localparam int IW = lrgd_pkg::IDX_W;

   lrgd_pkg::ctrl_state_type state_ff, state_in;
   logic [NW-1:0] held_ff, held_in, n_ff, n_in;
   logic [PW-1:0] p_ff, p_in;
   logic [IW-1:0] k_ff, k_in, fc_ff, fc_in, fc_eff;
   logic [15:0]   epoch_ff, epoch_in, lim_eff, epoch_next;
   logic          pass_ff, pass_in;
   logic          accept, room, last_p, last_k, stop;

   always_comb begin
      if (cfg_fc == 3'd0) fc_eff = IW'(1);
      else if (int'(cfg_fc) > MAX_FEATURES) fc_eff = IW'(MAX_FEATURES);
      else fc_eff = IW'(cfg_fc);
      lim_eff    = (cfg_lim == 16'd0) ? 16'd1 : cfg_lim;
      epoch_next = epoch_ff + 16'd1;
      accept     = (state_ff == lrgd_pkg::ST_IDLE) && req_valid;
      room       = held_ff < NW'(MAX_POINTS);
      last_p     = (NW'(p_ff) + NW'(1)) == n_ff;
      last_k     = k_ff == fc_ff;
      stop       = status.conv_hit || (epoch_next >= lim_eff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrgd_pkg::ST_IDLE:      if (accept && req_final) state_in = lrgd_pkg::ST_INIT;
         lrgd_pkg::ST_INIT:      state_in = lrgd_pkg::ST_EPOCH;
         lrgd_pkg::ST_EPOCH:     state_in = lrgd_pkg::ST_READ;
         lrgd_pkg::ST_READ:      state_in = lrgd_pkg::ST_PRED0;
         lrgd_pkg::ST_PRED0:     state_in = lrgd_pkg::ST_PMUL;
         lrgd_pkg::ST_PMUL:      state_in = lrgd_pkg::ST_PACC;
         lrgd_pkg::ST_PACC:      state_in = last_k ? lrgd_pkg::ST_RES : lrgd_pkg::ST_PMUL;
         lrgd_pkg::ST_RES:       state_in = pass_ff ? lrgd_pkg::ST_GMUL : lrgd_pkg::ST_SQMUL;
         lrgd_pkg::ST_GMUL:      state_in = lrgd_pkg::ST_GACC;
         lrgd_pkg::ST_GACC: begin
            if (!last_k) state_in = lrgd_pkg::ST_GMUL;
            else if (last_p) state_in = lrgd_pkg::ST_DIVG;
            else state_in = lrgd_pkg::ST_READ;
         end
         lrgd_pkg::ST_SQMUL:     state_in = lrgd_pkg::ST_SQACC;
         lrgd_pkg::ST_SQACC:     state_in = last_p ? lrgd_pkg::ST_DIVE : lrgd_pkg::ST_READ;
         lrgd_pkg::ST_DIVG:      state_in = lrgd_pkg::ST_DIVG_WAIT;
         lrgd_pkg::ST_DIVG_WAIT: if (status.div_done) state_in = lrgd_pkg::ST_LRMUL;
         lrgd_pkg::ST_LRMUL:     state_in = lrgd_pkg::ST_WACC;
         lrgd_pkg::ST_WACC:      state_in = last_k ? lrgd_pkg::ST_READ : lrgd_pkg::ST_DIVG;
         lrgd_pkg::ST_DIVE:      state_in = lrgd_pkg::ST_DIVE_WAIT;
         lrgd_pkg::ST_DIVE_WAIT: if (status.div_done) state_in = lrgd_pkg::ST_CHECK;
         lrgd_pkg::ST_CHECK:     state_in = stop ? lrgd_pkg::ST_LOAD : lrgd_pkg::ST_EPOCH;
         lrgd_pkg::ST_LOAD:      state_in = lrgd_pkg::ST_SEND;
         lrgd_pkg::ST_SEND: begin
            if (rsp_ready) state_in = last_k ? lrgd_pkg::ST_IDLE : lrgd_pkg::ST_LOAD;
         end
         default:                state_in = lrgd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      held_in  = held_ff;
      n_in     = n_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      fc_in    = fc_ff;
      epoch_in = epoch_ff;
      pass_in  = pass_ff;
      case (state_ff)
         lrgd_pkg::ST_IDLE: begin
            if (accept) begin
               if (room) held_in = held_ff + NW'(1);
               if (req_final) begin
                  n_in    = room ? held_ff + NW'(1) : held_ff;
                  held_in = '0;
                  fc_in   = fc_eff;
               end
            end
         end
         lrgd_pkg::ST_INIT:  epoch_in = '0;
         lrgd_pkg::ST_EPOCH: begin
            pass_in = 1'b1;
            p_in    = '0;
         end
         lrgd_pkg::ST_PRED0: k_in = IW'(1);
         lrgd_pkg::ST_PACC:  if (!last_k) k_in = k_ff + IW'(1);
         lrgd_pkg::ST_RES:   k_in = IW'(1);
         lrgd_pkg::ST_GACC: begin
            if (!last_k) k_in = k_ff + IW'(1);
            else if (last_p) begin
               p_in = '0;
               k_in = '0;
            end else p_in = p_ff + PW'(1);
         end
         lrgd_pkg::ST_SQACC: begin
            if (last_p) p_in = '0;
            else p_in = p_ff + PW'(1);
         end
         lrgd_pkg::ST_WACC: begin
            if (last_k) begin
               pass_in = 1'b0;
               p_in    = '0;
            end else k_in = k_ff + IW'(1);
         end
         lrgd_pkg::ST_CHECK: begin
            epoch_in = epoch_next;
            k_in     = '0;
         end
         lrgd_pkg::ST_SEND:  if (rsp_ready && !last_k) k_in = k_ff + IW'(1);
         default: ;
      endcase
   end

   always_comb begin
      cmd.op    = lrgd_pkg::OP_NOP;
      cmd.idx   = k_ff;
      cmd.last  = last_k;
      addr      = p_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         lrgd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            addr      = held_ff[PW-1:0];
            if (accept && room) cmd.op = lrgd_pkg::OP_STORE;
         end
         lrgd_pkg::ST_INIT:      cmd.op = lrgd_pkg::OP_INIT_RUN;
         lrgd_pkg::ST_EPOCH:     cmd.op = lrgd_pkg::OP_CLR_EPOCH;
         lrgd_pkg::ST_READ:      cmd.op = lrgd_pkg::OP_READ;
         lrgd_pkg::ST_PRED0:     cmd.op = lrgd_pkg::OP_PRED_INIT;
         lrgd_pkg::ST_PMUL:      cmd.op = lrgd_pkg::OP_MUL_WX;
         lrgd_pkg::ST_PACC:      cmd.op = lrgd_pkg::OP_ACC_PRED;
         lrgd_pkg::ST_RES:       cmd.op = pass_ff ? lrgd_pkg::OP_RES_G : lrgd_pkg::OP_RES_E;
         lrgd_pkg::ST_GMUL:      cmd.op = lrgd_pkg::OP_MUL_RX;
         lrgd_pkg::ST_GACC:      cmd.op = lrgd_pkg::OP_ACC_GRAD;
         lrgd_pkg::ST_SQMUL:     cmd.op = lrgd_pkg::OP_MUL_RR;
         lrgd_pkg::ST_SQACC:     cmd.op = lrgd_pkg::OP_ACC_SQ;
         lrgd_pkg::ST_DIVG:      cmd.op = lrgd_pkg::OP_DIV_GRAD;
         lrgd_pkg::ST_DIVG_WAIT: cmd.op = lrgd_pkg::OP_WAIT_G;
         lrgd_pkg::ST_LRMUL:     cmd.op = lrgd_pkg::OP_MUL_LR;
         lrgd_pkg::ST_WACC:      cmd.op = lrgd_pkg::OP_ACC_W;
         lrgd_pkg::ST_DIVE:      cmd.op = lrgd_pkg::OP_DIV_ERR;
         lrgd_pkg::ST_DIVE_WAIT: cmd.op = lrgd_pkg::OP_WAIT_E;
         lrgd_pkg::ST_CHECK:     cmd.op = lrgd_pkg::OP_CHECK;
         lrgd_pkg::ST_LOAD:      cmd.op = lrgd_pkg::OP_LOAD_OUT;
         lrgd_pkg::ST_SEND:      rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrgd_pkg::ST_IDLE;
         held_ff  <= '0;
         n_ff     <= '0;
         p_ff     <= '0;
         k_ff     <= '0;
         fc_ff    <= IW'(1);
         epoch_ff <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         n_ff     <= n_in;
         p_ff     <= p_in;
         k_ff     <= k_in;
         fc_ff    <= fc_in;
         epoch_ff <= epoch_in;
         pass_ff  <= pass_in;
      end
   end

   assign n = n_ff;
endmodule
`default_nettype wire

FILE: rtl/core/lrgd_checker.sv
`default_nettype none
`include "linear_regression_gradient_descent_assert.svh"
module lrgd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_weight_index,
   input logic [31:0] rsp_weight_value,
   input logic        rsp_last_weight
);
   logic rsp_last_xfer;

   assign rsp_last_xfer = rsp_valid && rsp_ready && rsp_last_weight;

   // hold a stalled result
   `LRGD_ASSERT_HOLD(a_rsp_hold_value, clock, reset, rsp_valid, rsp_ready, rsp_weight_value)
   `LRGD_ASSERT_HOLD(a_rsp_hold_index, clock, reset, rsp_valid, rsp_ready, rsp_weight_index)
   `LRGD_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `LRGD_ASSERT_NEXT(a_run_ends, clock, reset, rsp_last_xfer, req_ready && !rsp_valid)
endmodule

bind linear_regression_gradient_descent lrgd_checker u_lrgd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_weight_index (rsp_ch.weight_index),
   .rsp_weight_value (rsp_ch.weight_value),
   .rsp_last_weight  (rsp_ch.last_weight)
);
`default_nettype wire
